/* src/x25_facility_field_parser_core_defines.svh */
// Assertion macros used by the back end of the facility field parser.
`ifndef X25_FACILITY_FIELD_PARSER_CORE_DEFINES_SVH
`define X25_FACILITY_FIELD_PARSER_CORE_DEFINES_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define X25FFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define X25FFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/x25ffp_pkg.sv */
// Types, constants and the facility code table of the facility field parser.
package x25ffp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Byte classes reported with each result beat.
    localparam logic [3:0] CLS_DTE_LEN = 4'd0;
    localparam logic [3:0] CLS_DTE_ADR = 4'd1;
    localparam logic [3:0] CLS_FAC_LEN = 4'd2;
    localparam logic [3:0] CLS_CODE    = 4'd3;
    localparam logic [3:0] CLS_PLEN    = 4'd4;
    localparam logic [3:0] CLS_PARAM   = 4'd5;
    localparam logic [3:0] CLS_CALLING = 4'd6;
    localparam logic [3:0] CLS_CALLED  = 4'd7;
    localparam logic [3:0] CLS_AFTER   = 4'd8;

    localparam logic [7:0] CODE_CALLING_NSAP = 8'hcb;
    localparam logic [7:0] CODE_CALLED_NSAP  = 8'hc9;

    typedef enum logic [3:0] {
        PH_AFTER,
        PH_DTE,
        PH_FLEN,
        PH_CODE,
        PH_PLEN,
        PH_NLEN,
        PH_NIB,
        PH_NSAP,
        PH_PARAM
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [3:0] byte_class;
        logic [7:0] data_out;
        logic       addr_full;
        logic       addr_last;
        logic       facilities_done;
        logic       unknown_code;
    } t_out_item;

    // Pre-decoded byte as it waits in the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic [1:0] code_len;   // 0 means a length byte follows
        logic       code_unk;
        logic       is_nsap;
        logic       is_called;
        logic [3:0] dte_skip;
        logic [5:0] nib_addr;
        logic       nib_full;
    } t_pre;

    // Unknown-code flag and parameter length of a facility code; length 0 is variable length.
    function automatic logic [2:0] code_lookup(input logic [7:0] c);
        logic [1:0] len;
        logic       unk;
        begin
            unk = 1'b0;
            case (c)
                8'hca, 8'hc6, 8'hc5, 8'hc2, 8'hc1, 8'hc4, 8'hc3: len = 2'd0;
                8'h0a, 8'h02, 8'h03, 8'h47, 8'h0b, 8'h01, 8'h04, 8'h08, 8'h00: len = 2'd1;
                8'h42, 8'h43, 8'h44, 8'h41, 8'h49: len = 2'd2;
                default: begin
                    unk = 1'b1;
                    case (c[7:6])
                        2'b00:   len = 2'd1;
                        2'b01:   len = 2'd2;
                        2'b10:   len = 2'd3;
                        default: len = 2'd0;
                    endcase
                end
            endcase
            code_lookup = {unk, len};
        end
    endfunction

endpackage

/* src/x25ffp_front.sv */
// Front end: decodes every accepted byte in each way the back end may need it.
module x25ffp_front
    import x25ffp_pkg::*;
(
    input  t_in_item i_item,
    output t_pre     o_pre
);

    logic [2:0] w_code;
    logic [4:0] w_dte_sum;
    logic [6:0] w_nib_sum;
    logic       w_mode_ok;

    assign w_code    = code_lookup(i_item.data_byte);
    assign w_dte_sum = {1'b0, i_item.data_byte[7:4]} + {1'b0, i_item.data_byte[3:0]} + 5'd1;
    assign w_nib_sum = {1'b0, i_item.data_byte[5:0]} + 7'd1;
    // Only the entire and partial trailing modes carry address bytes.
    assign w_mode_ok = !i_item.data_byte[7];

    always_comb begin
        o_pre.data_byte = i_item.data_byte;
        o_pre.start_req = i_item.start_req;
        o_pre.code_len  = w_code[1:0];
        o_pre.code_unk  = w_code[2];
        o_pre.is_nsap   = (i_item.data_byte == CODE_CALLING_NSAP) ||
                          (i_item.data_byte == CODE_CALLED_NSAP);
        o_pre.is_called = (i_item.data_byte == CODE_CALLED_NSAP);
        o_pre.dte_skip  = w_dte_sum[4:1];
        o_pre.nib_addr  = w_mode_ok ? w_nib_sum[6:1] : 6'd0;
        o_pre.nib_full  = (i_item.data_byte[7:6] == 2'b00);
    end

endmodule

/* src/x25ffp_queue.sv */
// Short queue of decoded bytes between the front and the back end.
module x25ffp_queue
    import x25ffp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pre i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_pre o_data
);

    t_pre                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == QUEUE_DEPTH[QUEUE_AW:0]);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/x25ffp_back.sv */
// Back end: walks the call packet fields and registers one result per byte.
`include "x25_facility_field_parser_core_defines.svh"

module x25ffp_back
    import x25ffp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_pre      i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_skip, n_skip;
    logic [7:0] r_fac, n_fac;
    logic [7:0] r_param, n_param;
    logic [5:0] r_addr, n_addr;
    logic       r_called, n_called;
    logic       r_full, n_full;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic       w_pop;
    logic       w_in_facil;

    assign w_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_AFTER;
            r_skip   <= '0;
            r_fac    <= '0;
            r_param  <= '0;
            r_addr   <= '0;
            r_called <= 1'b0;
            r_full   <= 1'b0;
        end else if (w_pop) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_fac    <= n_fac;
            r_param  <= n_param;
            r_addr   <= n_addr;
            r_called <= n_called;
            r_full   <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_fac      = r_fac;
        n_param    = r_param;
        n_addr     = r_addr;
        n_called   = r_called;
        n_full     = r_full;
        w_in_facil = 1'b0;
        n_out                 = '0;
        n_out.byte_class      = CLS_AFTER;
        n_out.data_out        = i_q_data.data_byte;

        if (i_q_data.start_req) begin
            n_out.byte_class = CLS_DTE_LEN;
            n_skip   = i_q_data.dte_skip;
            n_fac    = '0;
            n_param  = '0;
            n_addr   = '0;
            n_called = 1'b0;
            n_full   = 1'b0;
            n_phase  = (i_q_data.dte_skip != '0) ? PH_DTE : PH_FLEN;
        end else begin
            case (r_phase)
                PH_DTE: begin
                    n_out.byte_class = CLS_DTE_ADR;
                    n_skip  = r_skip - 1'b1;
                    n_phase = (n_skip != '0) ? PH_DTE : PH_FLEN;
                end
                PH_FLEN: begin
                    n_out.byte_class = CLS_FAC_LEN;
                    n_fac = i_q_data.data_byte;
                    if (i_q_data.data_byte == '0) begin
                        n_out.facilities_done = 1'b1;
                        n_phase = PH_AFTER;
                    end else begin
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    n_out.byte_class = CLS_CODE;
                    w_in_facil = 1'b1;
                    if (i_q_data.is_nsap) begin
                        n_called = i_q_data.is_called;
                        n_phase  = PH_NLEN;
                    end else begin
                        n_out.unknown_code = i_q_data.code_unk;
                        if (i_q_data.code_len == '0) begin
                            n_phase = PH_PLEN;
                        end else begin
                            n_param = {6'd0, i_q_data.code_len};
                            n_phase = PH_PARAM;
                        end
                    end
                end
                PH_PLEN, PH_NLEN: begin
                    n_out.byte_class = CLS_PLEN;
                    w_in_facil = 1'b1;
                    n_param = i_q_data.data_byte;
                    if (i_q_data.data_byte == '0) begin
                        n_phase = PH_CODE;
                    end else begin
                        n_phase = (r_phase == PH_NLEN) ? PH_NIB : PH_PARAM;
                    end
                end
                PH_NIB: begin
                    n_out.byte_class = CLS_PLEN;
                    w_in_facil = 1'b1;
                    n_param = r_param - 1'b1;
                    n_full  = i_q_data.nib_full;
                    n_addr  = i_q_data.nib_addr;
                    if (n_param == '0) begin
                        n_phase = PH_CODE;
                    end else begin
                        n_phase = (i_q_data.nib_addr != '0) ? PH_NSAP : PH_PARAM;
                    end
                end
                PH_NSAP: begin
                    n_out.byte_class = r_called ? CLS_CALLED : CLS_CALLING;
                    w_in_facil = 1'b1;
                    n_out.addr_full = r_full;
                    n_param = r_param - 1'b1;
                    n_addr  = r_addr - 1'b1;
                    // The address also ends where its facility or the whole field ends.
                    n_out.addr_last = (n_param == '0) || (n_addr == '0) || (r_fac == 8'd1);
                    if (n_param == '0) begin
                        n_phase = PH_CODE;
                    end else begin
                        n_phase = (n_addr != '0) ? PH_NSAP : PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    n_out.byte_class = CLS_PARAM;
                    w_in_facil = 1'b1;
                    n_param = r_param - 1'b1;
                    n_phase = (n_param != '0) ? PH_PARAM : PH_CODE;
                end
                default: begin
                    n_phase = PH_AFTER;
                end
            endcase

            if (w_in_facil) begin
                n_fac = r_fac - 1'b1;
                if (n_fac == '0) begin
                    n_out.facilities_done = 1'b1;
                    n_phase = PH_AFTER;
                end
            end
        end
    end

    `X25FFP_ASSERT(a_last_on_nsap, !r_out_valid || !r_out.addr_last || (r_out.byte_class == CLS_CALLING) || (r_out.byte_class == CLS_CALLED), "addr_last on a byte that is no NSAP byte")
    `X25FFP_ASSERT(a_unk_on_code, !r_out_valid || !r_out.unknown_code || (r_out.byte_class == CLS_CODE), "unknown_code on a byte that is no code byte")
    `X25FFP_ASSERT(a_nsap_counts, (r_phase != PH_NSAP) || ((r_addr != '0) && (r_param != '0)), "NSAP phase with an empty address or parameter count")
    `X25FFP_ASSERT(a_param_count, (r_phase != PH_PARAM) || (r_param != '0), "parameter phase with an empty count")
    `X25FFP_ASSERT_NEXT(a_done_ends, w_pop && n_out.facilities_done, r_phase == PH_AFTER, "facility field ended but the walk goes on")

endmodule

/* src/x25_facility_field_parser_core.sv */
// Top level of the X.25 call packet facility field parser.
//
//   Channel  Direction  Handshake                  Beat
//   input    in         i_in_valid / o_in_ready    t_in_item  (one data area byte)
//   output   out        o_out_valid / i_out_ready  t_out_item (class of that byte)
//
// One byte is accepted per cycle while the queue has room; each byte passes the
// decode queue register stage and then the result register on its way out.
// Reset is synchronous; the parser then waits for a start byte and gives class 8.
// A four-beat queue lets input keep flowing while output is stalled, until the queue is full.
module x25_facility_field_parser_core
    import x25ffp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_pre w_pre;
    t_pre w_q_data;
    logic w_q_full;
    logic w_q_valid;
    logic w_q_pop;

    // No beat is taken while reset is held.
    assign o_in_ready = i_rst_n && !w_q_full;

    x25ffp_front u_front (
        .i_item (i_in_item),
        .o_pre  (w_pre)
    );

    x25ffp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && o_in_ready),
        .i_data  (w_pre),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    x25ffp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
